>>> hw/rtl/tpce_pkg.sv
// Shared types, register codes and constants of the tiled pixel colour effect block.
`default_nettype none

package tpce_pkg;

   // Register field widths.
   localparam int GRID_SIDE_W   = 3;
   localparam int CFG_SIZE_W    = 13;
   localparam int TABLE_ENTRIES = 16;
   localparam int TABLE_IDX_W   = 4;
   localparam int EFFECT_W      = 3;
   localparam int TABLE_W       = TABLE_ENTRIES * EFFECT_W;
   localparam int TILE_CNT_W    = 3;
   localparam int CHANNEL_W     = 8;

   // Configuration port geometry: 64-bit data, registers at 8-byte steps.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_LO = 3;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_GRID_SIDE = 4;
   localparam int DEF_MAX_DIMENSION = 4096;

   // Register values after reset.
   localparam logic [GRID_SIDE_W-1:0] RST_GRID_SIDE    = 3'd2;
   localparam logic [CFG_SIZE_W-1:0]  RST_TILE_WIDTH   = 13'd320;
   localparam logic [CFG_SIZE_W-1:0]  RST_TILE_HEIGHT  = 13'd240;
   localparam logic [CFG_SIZE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [CFG_SIZE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [TABLE_W-1:0]     RST_EFFECT_TABLE = '0;

   // A tile counter stops here, which always lies beyond the grid.
   localparam logic [TILE_CNT_W-1:0] TILE_SAT = 3'd7;

   // Grey weights, summing to 1024 so the result is taken from bit 10 up.
   localparam int GRAY_SUM_W = 18;
   localparam int GRAY_SHIFT = 10;
   localparam logic [GRAY_SUM_W-1:0] GRAY_R = 18'd307;
   localparam logic [GRAY_SUM_W-1:0] GRAY_G = 18'd604;
   localparam logic [GRAY_SUM_W-1:0] GRAY_B = 18'd113;
   localparam logic [CHANNEL_W-1:0]  CHANNEL_MAX = 8'hff;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_W-CSR_IDX_LO-1:0] {
      REG_GRID_SIDE    = 3'd0,
      REG_TILE_WIDTH   = 3'd1,
      REG_TILE_HEIGHT  = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4,
      REG_EFFECT_TABLE = 3'd5
   } reg_index_type;

   // Effect codes; the remaining codes pass the pixel through.
   typedef enum logic [EFFECT_W-1:0] {
      EFFECT_CLEAR_RED   = 3'd0,
      EFFECT_CLEAR_GREEN = 3'd1,
      EFFECT_CLEAR_BLUE  = 3'd2,
      EFFECT_GRAY        = 3'd3,
      EFFECT_INVERT      = 3'd4
   } effect_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] red_in;
      logic [CHANNEL_W-1:0] green_in;
      logic [CHANNEL_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] red_out;
      logic [CHANNEL_W-1:0] green_out;
      logic [CHANNEL_W-1:0] blue_out;
      logic                 frame_end;
   } rsp_type;

   typedef struct packed {
      logic [GRID_SIDE_W-1:0] grid_side;
      logic [CFG_SIZE_W-1:0]  tile_width;
      logic [CFG_SIZE_W-1:0]  tile_height;
      logic [CFG_SIZE_W-1:0]  image_width;
      logic [CFG_SIZE_W-1:0]  image_height;
      logic [TABLE_W-1:0]     effect_table;
   } cfg_type;

   // What the position tracker tells the colour stage about one pixel.
   typedef struct packed {
      logic [EFFECT_W-1:0] code;
      logic                in_grid;
      logic                frame_end;
   } tile_info_type;

   typedef struct packed {
      req_type       pixel;
      tile_info_type info;
   } pixel_stage_type;

endpackage

`default_nettype wire

>>> hw/rtl/tpce_tile_counter.sv
// Raster position and tile counters with the effect table lookup.
`default_nettype none

module tpce_tile_counter #(
   parameter int MAX_GRID_SIDE = tpce_pkg::DEF_MAX_GRID_SIDE,
   parameter int MAX_DIMENSION = tpce_pkg::DEF_MAX_DIMENSION
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire tpce_pkg::cfg_type       cfg,
   output tpce_pkg::tile_info_type      info
);

   localparam int DIM_W  = $clog2(MAX_DIMENSION);
   localparam int SW     = (tpce_pkg::CFG_SIZE_W > DIM_W + 1) ? tpce_pkg::CFG_SIZE_W : DIM_W + 1;
   localparam int SIDE_W = ($clog2(MAX_GRID_SIDE + 1) > tpce_pkg::GRID_SIDE_W) ?
                           $clog2(MAX_GRID_SIDE + 1) : tpce_pkg::GRID_SIDE_W;
   localparam int IW     = tpce_pkg::TILE_CNT_W + SIDE_W;

   // A size of zero acts as one, a size above the maximum as the maximum.
   function automatic logic [SW-1:0] size_limit(input logic [tpce_pkg::CFG_SIZE_W-1:0] v);
      logic [SW-1:0] wide;
      logic [SW-1:0] clamped;
      wide = SW'(v);
      if (wide == '0) begin
         clamped = SW'(1);
      end else if (wide > SW'(MAX_DIMENSION)) begin
         clamped = SW'(MAX_DIMENSION);
      end else begin
         clamped = wide;
      end
      return clamped - SW'(1);
   endfunction

   function automatic logic [tpce_pkg::TILE_CNT_W-1:0] tile_inc(
         input logic [tpce_pkg::TILE_CNT_W-1:0] t);
      return (t == tpce_pkg::TILE_SAT) ? t : t + tpce_pkg::TILE_CNT_W'(1);
   endfunction

   logic [DIM_W-1:0] column_count_ff, column_count_in;
   logic [DIM_W-1:0] row_count_ff, row_count_in;
   logic [DIM_W-1:0] column_in_tile_ff, column_in_tile_in;
   logic [DIM_W-1:0] row_in_tile_ff, row_in_tile_in;
   logic [tpce_pkg::TILE_CNT_W-1:0] tile_column_ff, tile_column_in;
   logic [tpce_pkg::TILE_CNT_W-1:0] tile_row_ff, tile_row_in;

   logic [SW-1:0]     tw_lim, th_lim, iw_lim, ih_lim;
   logic              last_col, last_row;
   logic [SIDE_W-1:0] side;
   logic [IW-1:0]     index_full;
   logic [tpce_pkg::TABLE_IDX_W-1:0] index;

   assign tw_lim = size_limit(cfg.tile_width);
   assign th_lim = size_limit(cfg.tile_height);
   assign iw_lim = size_limit(cfg.image_width);
   assign ih_lim = size_limit(cfg.image_height);

   assign last_col = SW'(column_count_ff) >= iw_lim;
   assign last_row = SW'(row_count_ff) >= ih_lim;

   // Grid side clamped into 1..MAX_GRID_SIDE.
   always_comb begin
      if (cfg.grid_side == '0) begin
         side = SIDE_W'(1);
      end else if (SIDE_W'(cfg.grid_side) > SIDE_W'(MAX_GRID_SIDE)) begin
         side = SIDE_W'(MAX_GRID_SIDE);
      end else begin
         side = SIDE_W'(cfg.grid_side);
      end
   end

   // Table entry chosen by column-major tile index; only its low bits count.
   assign index_full = IW'(tile_column_ff) * IW'(side) + IW'(tile_row_ff);
   assign index      = index_full[tpce_pkg::TABLE_IDX_W-1:0];

   assign info.code      = cfg.effect_table[index * tpce_pkg::EFFECT_W +: tpce_pkg::EFFECT_W];
   assign info.in_grid   = (SIDE_W'(tile_column_ff) < side) && (SIDE_W'(tile_row_ff) < side);
   assign info.frame_end = last_col && last_row;

   // Counter advance for one accepted word.
   always_comb begin
      column_count_in   = column_count_ff;
      row_count_in      = row_count_ff;
      column_in_tile_in = column_in_tile_ff;
      row_in_tile_in    = row_in_tile_ff;
      tile_column_in    = tile_column_ff;
      tile_row_in       = tile_row_ff;
      if (advance) begin
         if (last_col) begin
            column_count_in   = '0;
            column_in_tile_in = '0;
            tile_column_in    = '0;
            if (last_row) begin
               row_count_in   = '0;
               row_in_tile_in = '0;
               tile_row_in    = '0;
            end else begin
               row_count_in = row_count_ff + DIM_W'(1);
               if (SW'(row_in_tile_ff) >= th_lim) begin
                  row_in_tile_in = '0;
                  tile_row_in    = tile_inc(tile_row_ff);
               end else begin
                  row_in_tile_in = row_in_tile_ff + DIM_W'(1);
               end
            end
         end else begin
            column_count_in = column_count_ff + DIM_W'(1);
            if (SW'(column_in_tile_ff) >= tw_lim) begin
               column_in_tile_in = '0;
               tile_column_in    = tile_inc(tile_column_ff);
            end else begin
               column_in_tile_in = column_in_tile_ff + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff   <= '0;
         row_count_ff      <= '0;
         column_in_tile_ff <= '0;
         row_in_tile_ff    <= '0;
         tile_column_ff    <= '0;
         tile_row_ff       <= '0;
      end else begin
         column_count_ff   <= column_count_in;
         row_count_ff      <= row_count_in;
         column_in_tile_ff <= column_in_tile_in;
         row_in_tile_ff    <= row_in_tile_in;
         tile_column_ff    <= tile_column_in;
         tile_row_ff       <= tile_row_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/tpce_color_effect.sv
// Colour effect applied to one pixel according to its tile's code.
`default_nettype none

module tpce_color_effect (
   input  wire tpce_pkg::pixel_stage_type stage,
   output tpce_pkg::rsp_type              result
);

   logic [tpce_pkg::GRAY_SUM_W-1:0] gray_sum;
   logic [tpce_pkg::CHANNEL_W-1:0]  gray;
   logic [tpce_pkg::CHANNEL_W-1:0]  r, g, b;

   assign r = stage.pixel.red_in;
   assign g = stage.pixel.green_in;
   assign b = stage.pixel.blue_in;

   // Weighted sum for the grey effect.
   assign gray_sum = tpce_pkg::GRAY_SUM_W'(r) * tpce_pkg::GRAY_R
                   + tpce_pkg::GRAY_SUM_W'(g) * tpce_pkg::GRAY_G
                   + tpce_pkg::GRAY_SUM_W'(b) * tpce_pkg::GRAY_B;
   assign gray = gray_sum[tpce_pkg::GRAY_SHIFT +: tpce_pkg::CHANNEL_W];

   // Effect select; pixels outside the grid come out black.
   always_comb begin
      result.frame_end = stage.info.frame_end;
      result.red_out   = r;
      result.green_out = g;
      result.blue_out  = b;
      if (!stage.info.in_grid) begin
         result.red_out   = '0;
         result.green_out = '0;
         result.blue_out  = '0;
      end else begin
         case (stage.info.code)
            tpce_pkg::EFFECT_CLEAR_RED: begin
               result.red_out = '0;
            end
            tpce_pkg::EFFECT_CLEAR_GREEN: begin
               result.green_out = '0;
            end
            tpce_pkg::EFFECT_CLEAR_BLUE: begin
               result.blue_out = '0;
            end
            tpce_pkg::EFFECT_GRAY: begin
               result.red_out   = gray;
               result.green_out = gray;
               result.blue_out  = gray;
            end
            tpce_pkg::EFFECT_INVERT: begin
               result.red_out   = tpce_pkg::CHANNEL_MAX - r;
               result.green_out = tpce_pkg::CHANNEL_MAX - g;
               result.blue_out  = tpce_pkg::CHANNEL_MAX - b;
            end
            default: begin
               result.red_out   = r;
               result.green_out = g;
               result.blue_out  = b;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/tiled_pixel_color_effect.sv
// Top level of the tiled pixel colour effect block: register port and two-stage pipeline.
//
// Pixels enter on the req_ channel in raster order, one word per accepted
// handshake, and leave on the rsp_ channel with their tile's colour effect
// applied and frame_end set on the last pixel of each frame.
// The pipeline has two registers: a pixel stage that captures the word with
// its tile code, grid flag and frame flag from the position counters, and a
// result register after the colour logic. An accepted word moves from the
// pixel stage into the result register, which drives rsp_; one word is
// accepted in every cycle while the receiver takes them. When the receiver
// stalls, the result register holds its word and the pixel stage takes one
// more; req_ready then falls until the receiver takes a word again.
// The csr_ port is an APB-style register interface with 64-bit data; register
// i sits at byte address 8*i and pready is always high. The user must write
// it only while no pixel is in flight; the block itself does not enforce this.
// Synchronous reset empties the pipeline, returns the position counters to the
// top left of the frame and loads every register with its default value.
`default_nettype none

module tiled_pixel_color_effect #(
   parameter int MAX_GRID_SIDE = tpce_pkg::DEF_MAX_GRID_SIDE,
   parameter int MAX_DIMENSION = tpce_pkg::DEF_MAX_DIMENSION
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire tpce_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output tpce_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tpce_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [tpce_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tpce_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   tpce_pkg::cfg_type         cfg_ff, cfg_in;
   tpce_pkg::reg_index_type   reg_index;
   logic                      csr_write;

   tpce_pkg::tile_info_type   info;
   tpce_pkg::pixel_stage_type stage_ff, stage_in;
   logic                      stage_valid_ff, stage_valid_in;
   tpce_pkg::rsp_type         result;
   tpce_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      req_accept;
   logic                      out_ready;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign reg_index  = tpce_pkg::reg_index_type'(
                          csr_paddr[tpce_pkg::CSR_ADDR_W-1:tpce_pkg::CSR_IDX_LO]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            tpce_pkg::REG_GRID_SIDE:
               cfg_in.grid_side = csr_pwdata[tpce_pkg::GRID_SIDE_W-1:0];
            tpce_pkg::REG_TILE_WIDTH:
               cfg_in.tile_width = csr_pwdata[tpce_pkg::CFG_SIZE_W-1:0];
            tpce_pkg::REG_TILE_HEIGHT:
               cfg_in.tile_height = csr_pwdata[tpce_pkg::CFG_SIZE_W-1:0];
            tpce_pkg::REG_IMAGE_WIDTH:
               cfg_in.image_width = csr_pwdata[tpce_pkg::CFG_SIZE_W-1:0];
            tpce_pkg::REG_IMAGE_HEIGHT:
               cfg_in.image_height = csr_pwdata[tpce_pkg::CFG_SIZE_W-1:0];
            tpce_pkg::REG_EFFECT_TABLE:
               cfg_in.effect_table = csr_pwdata[tpce_pkg::TABLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_index)
         tpce_pkg::REG_GRID_SIDE:    csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.grid_side);
         tpce_pkg::REG_TILE_WIDTH:   csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.tile_width);
         tpce_pkg::REG_TILE_HEIGHT:  csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.tile_height);
         tpce_pkg::REG_IMAGE_WIDTH:  csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.image_width);
         tpce_pkg::REG_IMAGE_HEIGHT: csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.image_height);
         tpce_pkg::REG_EFFECT_TABLE: csr_prdata = tpce_pkg::CSR_DATA_W'(cfg_ff.effect_table);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_side    <= tpce_pkg::RST_GRID_SIDE;
         cfg_ff.tile_width   <= tpce_pkg::RST_TILE_WIDTH;
         cfg_ff.tile_height  <= tpce_pkg::RST_TILE_HEIGHT;
         cfg_ff.image_width  <= tpce_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height <= tpce_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.effect_table <= tpce_pkg::RST_EFFECT_TABLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: each stage loads when it is empty or its word moves on.
   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !stage_valid_ff || out_ready;
   assign req_accept = req_valid && req_ready;

   tpce_tile_counter #(
      .MAX_GRID_SIDE (MAX_GRID_SIDE),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_counter (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .cfg     (cfg_ff),
      .info    (info)
   );

   // Pixel stage.
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      if (req_ready) begin
         stage_valid_in = req_valid;
         stage_in.pixel = req_data;
         stage_in.info  = info;
      end
   end

   tpce_color_effect u_effect (
      .stage  (stage_ff),
      .result (result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_ready) begin
         rsp_valid_in = stage_valid_ff;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A full pipeline facing a stalled receiver takes no more words.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("word accepted into a full pipeline");

   // An accepted word is held in the pixel stage on the next cycle.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stage_valid_ff)
      else $error("accepted word lost before the pixel stage");

   // A pixel stage word that cannot move on keeps its contents.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !out_ready) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("pixel stage word changed while blocked");

   // A word in the pixel stage moves to the result register when it is free.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && out_ready) |=> rsp_valid_ff)
      else $error("pixel stage word did not reach the result register");

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tiled pixel colour effect block.
module testbench;

   localparam int HALF_PERIOD     = 4;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int REPORT_LIMIT    = 40;
   localparam int DRAIN_CYCLES    = 8;
   localparam int SIDE_LIMIT      = tpce_pkg::DEF_MAX_GRID_SIDE;
   localparam int SIZE_LIMIT      = tpce_pkg::DEF_MAX_DIMENSION;
   localparam int TILE_LAST       = 7;
   localparam int GREY_RED        = 307;
   localparam int GREY_GREEN      = 604;
   localparam int GREY_BLUE       = 113;
   localparam int GREY_SHIFT      = 10;
   localparam int RANDOM_SEGMENTS = 13;
   localparam int SEGMENT_PIXELS  = 105;
   localparam int LARGE_PIXELS    = 40;
   localparam int SIZE_ALL_ONES   = 8191;
   localparam logic [tpce_pkg::EFFECT_W-1:0] EFFECT_PASS = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   tpce_pkg::req_type               req_data    = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   tpce_pkg::rsp_type               rsp_data;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [tpce_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [tpce_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [tpce_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Local copy of the registers, at their reset values.
   logic [tpce_pkg::GRID_SIDE_W-1:0] cfg_grid_side    = tpce_pkg::RST_GRID_SIDE;
   logic [tpce_pkg::CFG_SIZE_W-1:0]  cfg_tile_width   = tpce_pkg::RST_TILE_WIDTH;
   logic [tpce_pkg::CFG_SIZE_W-1:0]  cfg_tile_height  = tpce_pkg::RST_TILE_HEIGHT;
   logic [tpce_pkg::CFG_SIZE_W-1:0]  cfg_image_width  = tpce_pkg::RST_IMAGE_WIDTH;
   logic [tpce_pkg::CFG_SIZE_W-1:0]  cfg_image_height = tpce_pkg::RST_IMAGE_HEIGHT;
   logic [tpce_pkg::TABLE_W-1:0]     cfg_effect_table = tpce_pkg::RST_EFFECT_TABLE;

   // Position of the next pixel in the frame and in the tile grid.
   int unsigned pos_column         = 0;
   int unsigned pos_row            = 0;
   int unsigned pos_tile_column    = 0;
   int unsigned pos_column_in_tile = 0;
   int unsigned pos_tile_row       = 0;
   int unsigned pos_row_in_tile    = 0;

   tpce_pkg::rsp_type expected_pixels[$];
   int                mismatch_count     = 0;
   int                cycle_count        = 0;
   int                sender_idle_pct    = 0;
   int                receiver_stall_pct = 0;

   tiled_pixel_color_effect dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int unsigned fit_size(input int unsigned size);
      if (size == 0) return 1;
      if (size > SIZE_LIMIT) return SIZE_LIMIT;
      return size;
   endfunction

   function automatic int unsigned fit_side(input int unsigned side);
      if (side == 0) return 1;
      if (side > SIDE_LIMIT) return SIDE_LIMIT;
      return side;
   endfunction

   // Tile counters stop at the last value, which is always outside the grid.
   function automatic int unsigned next_tile(input int unsigned tile);
      return (tile >= TILE_LAST) ? TILE_LAST : tile + 1;
   endfunction

   // Works out the coloured word for one pixel and moves the position on.
   function automatic tpce_pkg::rsp_type apply_tile_effect(input tpce_pkg::req_type pix);
      int unsigned                   side, tile_w, tile_h, image_w, image_h, entry, grey;
      logic [tpce_pkg::EFFECT_W-1:0] code;
      logic                          last_column, last_row;
      tpce_pkg::rsp_type             result;
      side        = fit_side(cfg_grid_side);
      tile_w      = fit_size(cfg_tile_width);
      tile_h      = fit_size(cfg_tile_height);
      image_w     = fit_size(cfg_image_width);
      image_h     = fit_size(cfg_image_height);
      result      = '0;
      last_column = pos_column >= image_w - 1;
      last_row    = pos_row >= image_h - 1;

      // Pixels outside the grid stay black.
      if (pos_tile_column < side && pos_tile_row < side) begin
         entry = (pos_tile_column * side + pos_tile_row) % tpce_pkg::TABLE_ENTRIES;
         code  = cfg_effect_table[tpce_pkg::EFFECT_W*entry +: tpce_pkg::EFFECT_W];
         result.red_out   = pix.red_in;
         result.green_out = pix.green_in;
         result.blue_out  = pix.blue_in;
         case (code)
            tpce_pkg::EFFECT_CLEAR_RED:   result.red_out = '0;
            tpce_pkg::EFFECT_CLEAR_GREEN: result.green_out = '0;
            tpce_pkg::EFFECT_CLEAR_BLUE:  result.blue_out = '0;
            tpce_pkg::EFFECT_GRAY: begin
               grey = (GREY_RED * pix.red_in + GREY_GREEN * pix.green_in
                       + GREY_BLUE * pix.blue_in) >> GREY_SHIFT;
               result.red_out   = grey[tpce_pkg::CHANNEL_W-1:0];
               result.green_out = grey[tpce_pkg::CHANNEL_W-1:0];
               result.blue_out  = grey[tpce_pkg::CHANNEL_W-1:0];
            end
            tpce_pkg::EFFECT_INVERT: begin
               result.red_out   = ~pix.red_in;
               result.green_out = ~pix.green_in;
               result.blue_out  = ~pix.blue_in;
            end
            default: ;
         endcase
      end
      result.frame_end = last_column && last_row;

      // Raster advance; a counter at or past its limit wraps.
      if (last_column) begin
         pos_column         = 0;
         pos_column_in_tile = 0;
         pos_tile_column    = 0;
         if (last_row) begin
            pos_row         = 0;
            pos_row_in_tile = 0;
            pos_tile_row    = 0;
         end else begin
            pos_row++;
            if (pos_row_in_tile >= tile_h - 1) begin
               pos_row_in_tile = 0;
               pos_tile_row    = next_tile(pos_tile_row);
            end else begin
               pos_row_in_tile++;
            end
         end
      end else begin
         pos_column++;
         if (pos_column_in_tile >= tile_w - 1) begin
            pos_column_in_tile = 0;
            pos_tile_column    = next_tile(pos_tile_column);
         end else begin
            pos_column_in_tile++;
         end
      end
      return result;
   endfunction

   function automatic void store_register(input tpce_pkg::reg_index_type index,
                                          input logic [tpce_pkg::CSR_DATA_W-1:0] value);
      case (index)
         tpce_pkg::REG_GRID_SIDE:    cfg_grid_side    = value[tpce_pkg::GRID_SIDE_W-1:0];
         tpce_pkg::REG_TILE_WIDTH:   cfg_tile_width   = value[tpce_pkg::CFG_SIZE_W-1:0];
         tpce_pkg::REG_TILE_HEIGHT:  cfg_tile_height  = value[tpce_pkg::CFG_SIZE_W-1:0];
         tpce_pkg::REG_IMAGE_WIDTH:  cfg_image_width  = value[tpce_pkg::CFG_SIZE_W-1:0];
         tpce_pkg::REG_IMAGE_HEIGHT: cfg_image_height = value[tpce_pkg::CFG_SIZE_W-1:0];
         tpce_pkg::REG_EFFECT_TABLE: cfg_effect_table = value[tpce_pkg::TABLE_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [tpce_pkg::CSR_DATA_W-1:0] register_value(
         input tpce_pkg::reg_index_type index);
      case (index)
         tpce_pkg::REG_GRID_SIDE:    return tpce_pkg::CSR_DATA_W'(cfg_grid_side);
         tpce_pkg::REG_TILE_WIDTH:   return tpce_pkg::CSR_DATA_W'(cfg_tile_width);
         tpce_pkg::REG_TILE_HEIGHT:  return tpce_pkg::CSR_DATA_W'(cfg_tile_height);
         tpce_pkg::REG_IMAGE_WIDTH:  return tpce_pkg::CSR_DATA_W'(cfg_image_width);
         tpce_pkg::REG_IMAGE_HEIGHT: return tpce_pkg::CSR_DATA_W'(cfg_image_height);
         tpce_pkg::REG_EFFECT_TABLE: return tpce_pkg::CSR_DATA_W'(cfg_effect_table);
         default:                    return '0;
      endcase
   endfunction

   function automatic tpce_pkg::req_type random_pixel();
      tpce_pkg::req_type pix;
      pix.red_in   = tpce_pkg::CHANNEL_W'($urandom);
      pix.green_in = tpce_pkg::CHANNEL_W'($urandom);
      pix.blue_in  = tpce_pkg::CHANNEL_W'($urandom);
      return pix;
   endfunction

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input tpce_pkg::reg_index_type index,
                            input logic [tpce_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, {tpce_pkg::CSR_IDX_LO{1'b0}}};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      store_register(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Register read, compared with the local copy.
   task automatic check_register(input tpce_pkg::reg_index_type index);
      logic [tpce_pkg::CSR_DATA_W-1:0] value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, {tpce_pkg::CSR_IDX_LO{1'b0}}};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      if (value !== register_value(index))
         report_mismatch($sformatf("register %s reads %h, expected %h",
                                   index.name(), value, register_value(index)));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input int unsigned side, input int unsigned tile_w,
                            input int unsigned tile_h, input int unsigned image_w,
                            input int unsigned image_h,
                            input logic [tpce_pkg::CSR_DATA_W-1:0] table_word);
      csr_write(tpce_pkg::REG_GRID_SIDE, tpce_pkg::CSR_DATA_W'(side));
      csr_write(tpce_pkg::REG_TILE_WIDTH, tpce_pkg::CSR_DATA_W'(tile_w));
      csr_write(tpce_pkg::REG_TILE_HEIGHT, tpce_pkg::CSR_DATA_W'(tile_h));
      csr_write(tpce_pkg::REG_IMAGE_WIDTH, tpce_pkg::CSR_DATA_W'(image_w));
      csr_write(tpce_pkg::REG_IMAGE_HEIGHT, tpce_pkg::CSR_DATA_W'(image_h));
      csr_write(tpce_pkg::REG_EFFECT_TABLE, table_word);
   endtask

   task automatic set_idling(input idling_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
         default:       begin sender_idle_pct = 17; receiver_stall_pct = 17; end
      endcase
   endtask

   // Offers one pixel word and waits for it to be taken. Called at a falling
   // edge; valid is left high so that the next call or settle decides it.
   task automatic send_pixel(input tpce_pkg::req_type pix);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(apply_tile_effect(pix));
      @(negedge clock);
   endtask

   // Stops the sender and waits until every word in flight has come out.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic check_pixel(input tpce_pkg::rsp_type got);
      tpce_pkg::rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("word %h with nothing expected", got));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.red_out !== want.red_out)
         report_mismatch($sformatf("red_out %0d, expected %0d", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
         report_mismatch($sformatf("green_out %0d, expected %0d",
                                   got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
         report_mismatch($sformatf("blue_out %0d, expected %0d", got.blue_out, want.blue_out));
      if (got.frame_end !== want.frame_end)
         report_mismatch($sformatf("frame_end %b, expected %b",
                                   got.frame_end, want.frame_end));
   endtask

   // Receiver: stalls at random and checks every word it takes.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) check_pixel(rsp_data);
      end
   end

   // Reset values, then all ones and all zeros in every register.
   task automatic test_register_access();
      tpce_pkg::reg_index_type index;
      for (int i = tpce_pkg::REG_GRID_SIDE; i <= tpce_pkg::REG_EFFECT_TABLE; i++) begin
         index = tpce_pkg::reg_index_type'(i);
         check_register(index);
         csr_write(index, '1);
         check_register(index);
         csr_write(index, '0);
         check_register(index);
      end
   endtask

   // One-pixel tiles on a four by four grid, so that eight pixels reach
   // table entries 0 to 7 and every effect code, with channels at 0 and 255.
   task automatic test_effect_codes();
      logic [tpce_pkg::CSR_DATA_W-1:0] table_word;
      tpce_pkg::req_type               pix;
      settle();
      set_idling(IDLE_NONE);
      table_word = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
         table_word[tpce_pkg::EFFECT_W*i +: tpce_pkg::EFFECT_W] = tpce_pkg::EFFECT_W'(i);
      configure(4, 1, 1, 2, 4, table_word);
      for (int p = 0; p < 8; p++) begin
         pix.red_in   = {tpce_pkg::CHANNEL_W{p[0]}};
         pix.green_in = {tpce_pkg::CHANNEL_W{p[1]}};
         pix.blue_in  = {tpce_pkg::CHANNEL_W{p[2]}};
         send_pixel(pix);
      end
   endtask

   // A zero grid side and zero tile height act as one; a long row of
   // one-pixel tiles runs the tile column past the grid until it saturates.
   task automatic test_beyond_grid();
      logic [tpce_pkg::CSR_DATA_W-1:0] table_word;
      settle();
      table_word = {$urandom, $urandom};
      table_word[tpce_pkg::EFFECT_W-1:0] = EFFECT_PASS;
      configure(0, 1, 0, 9, 1, table_word);
      repeat (9) send_pixel(random_pixel());
   endtask

   // The image width shrinks below the column counter mid-row.
   task automatic test_shrunk_row();
      settle();
      configure(1, 3, 2, 6, 3, {$urandom, $urandom});
      repeat (4) send_pixel(random_pixel());
      settle();
      csr_write(tpce_pkg::REG_IMAGE_WIDTH, tpce_pkg::CSR_DATA_W'(2));
      repeat (3) send_pixel(random_pixel());
   endtask

   // Small random frames and grids under every idling mode.
   task automatic test_random_frames();
      int unsigned side, tile_w, tile_h, image_w, image_h;
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         settle();
         set_idling(idling_type'(seg % 4));
         side    = $urandom_range(7);
         tile_w  = $urandom_range(5);
         tile_h  = $urandom_range(4);
         image_w = $urandom_range(fit_side(side) * fit_size(tile_w) + 3);
         image_h = $urandom_range(fit_side(side) * fit_size(tile_h) + 2);
         configure(side, tile_w, tile_h, image_w, image_h, {$urandom, $urandom});
         repeat (SEGMENT_PIXELS) send_pixel(random_pixel());
      end
   endtask

   // Sizes at and above the largest dimension, for a short stretch only.
   task automatic test_large_sizes();
      settle();
      set_idling(IDLE_BOTH);
      configure(4, SIZE_ALL_ONES, SIZE_LIMIT, SIZE_ALL_ONES, SIZE_ALL_ONES,
                {$urandom, $urandom});
      repeat (LARGE_PIXELS) send_pixel(random_pixel());
   endtask

   // Test sequence.
   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_register_access();
      test_effect_codes();
      test_beyond_grid();
      test_shrunk_row();
      test_random_frames();
      test_large_sizes();
      settle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
